// ----- hdl/hpd_pkg.sv -----
// ----------------------------------------------------------------------------
// hpd_pkg
// shared types and constants of the multichannel hit peak detector
// ----------------------------------------------------------------------------
package hpd_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int SAMPLE_MAX = 255;
    localparam int IN_FIELDS  = 10;
    localparam int SEL_W      = 4;
    localparam int PEAK_W     = 16;
    localparam int MAP_DEPTH  = 12;

    // ring number of each channel
    localparam logic [SEL_W-1:0] RING_MAP [MAP_DEPTH] = '{
        4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd11, 4'd12
    };

    typedef struct packed {
        logic clear;
        logic base_add;
        logic ring_upd;
        logic win_open;
        logic win_track;
    } lane_ctrl_t;

endpackage

// ----- hdl/hpd_lane.sv -----
// ----------------------------------------------------------------------------
// hpd_lane
// one channel: running baseline sum, excess over baseline, hit flag, peak hold
// ----------------------------------------------------------------------------
module hpd_lane #(
    parameter int DEPTH = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hpd_pkg::lane_ctrl_t                   ctrl,
    input  logic [hpd_pkg::SAMPLE_W-1:0]          sample,
    input  logic [hpd_pkg::SAMPLE_W-1:0]          old_sample,
    input  logic [$clog2(hpd_pkg::SAMPLE_MAX*DEPTH+1)-1:0] limit,
    output logic                                  hit,
    output logic signed [$clog2(hpd_pkg::SAMPLE_MAX*DEPTH+1):0] peak_upd
);

    localparam int SUM_W = $clog2(hpd_pkg::SAMPLE_MAX * DEPTH + 1);

    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic signed [SUM_W:0]   peak_reg;
    logic [SUM_W-1:0]        sample_scaled;
    logic signed [SUM_W:0]   excess;
    logic [SUM_W:0]          sum_wide;
    logic [SUM_W:0]          old_term;

    assign sample_scaled = SUM_W'(sample) * SUM_W'(DEPTH);
    assign excess        = $signed({1'b0, sample_scaled}) - $signed({1'b0, sum_reg});
    assign hit           = excess > $signed({1'b0, limit});
    assign peak_upd      = (ctrl.win_track && (excess > peak_reg)) ? excess : peak_reg;

    assign old_term = ctrl.ring_upd ? (SUM_W+1)'(old_sample) : '0;
    assign sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(sample) - old_term;

    always_comb
    begin
        if (ctrl.clear)
        begin
            sum_next = '0;
        end
        else if (ctrl.base_add || ctrl.ring_upd)
        begin
            sum_next = sum_wide[SUM_W-1:0];
        end
        else
        begin
            sum_next = sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.win_open)
        begin
            peak_reg <= excess;
        end
        else if (ctrl.win_track)
        begin
            peak_reg <= peak_upd;
        end
    end

endmodule

// ----- hdl/hpd_merge.sv -----
// ----------------------------------------------------------------------------
// hpd_merge
// merges the lane peaks: argmax, tie check, ring mapping, scaling to hundredths
// ----------------------------------------------------------------------------
module hpd_merge #(
    parameter int CHANNELS = 10,
    parameter int DEPTH    = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  close,
    input  logic signed [$clog2(hpd_pkg::SAMPLE_MAX*DEPTH+1):0] peaks [CHANNELS],
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [hpd_pkg::SEL_W-1:0]             ring_number,
    output logic [hpd_pkg::PEAK_W-1:0]            peak_hundredths,
    output logic [hpd_pkg::SEL_W-1:0]             best_channel,
    output logic                                  ambiguous,
    output logic                                  busy
);

    localparam int SUM_W  = $clog2(hpd_pkg::SAMPLE_MAX * DEPTH + 1);
    localparam int EXC_W  = SUM_W + 1;
    localparam int NUM_W  = SUM_W + 8;
    localparam int K      = NUM_W + $clog2(DEPTH);
    localparam logic [63:0] RECIP = ((64'd1 << K) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
    localparam int M_W    = $clog2(RECIP + 64'd1);
    localparam int ML_W   = M_W / 2;
    localparam int MH_W   = M_W - ML_W;
    localparam int PW     = NUM_W + M_W;
    localparam int HALF   = (CHANNELS + 1) / 2;
    localparam int HALF_D = DEPTH / 2;
    localparam logic [ML_W-1:0] RECIP_LO = RECIP[ML_W-1:0];
    localparam logic [MH_W-1:0] RECIP_HI = RECIP[M_W-1:ML_W];
    localparam logic [NUM_W-1:0] SCALE   = NUM_W'(100);
    localparam logic [PW-1:0]    SAT_MAX = PW'(65535);

    logic                    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [EXC_W-1:0] pk_reg [CHANNELS];
    logic signed [EXC_W-1:0] max_lo_next, max_hi_next;
    logic signed [EXC_W-1:0] max_lo_reg, max_hi_reg;
    logic signed [EXC_W-1:0] mx;
    logic [CHANNELS-1:0]     eq;
    logic [hpd_pkg::SEL_W-1:0] best_next;
    logic signed [EXC_W-1:0] mx3_reg;
    logic [hpd_pkg::SEL_W-1:0] best3_reg, best4_reg, best5_reg;
    logic                    tied3_reg, tied4_reg, tied5_reg;
    logic [NUM_W-1:0]        num_next, num4_reg;
    logic [NUM_W+ML_W-1:0]   pp_lo_reg;
    logic [NUM_W+MH_W-1:0]   pp_hi_reg;
    logic [PW-1:0]           prod;
    logic [PW-1:0]           quot;
    logic                    out_valid_reg;
    logic [hpd_pkg::SEL_W-1:0] ring_reg, best_out_reg;
    logic [hpd_pkg::PEAK_W-1:0] peak_out_reg;
    logic                    tied_out_reg;

    // half maxima
    always_comb
    begin
        max_lo_next = pk_reg[0];
        for (int ch = 1; ch < HALF; ch++)
        begin
            if (pk_reg[ch] > max_lo_next)
            begin
                max_lo_next = pk_reg[ch];
            end
        end
        max_hi_next = {1'b1, {(EXC_W-1){1'b0}}};
        for (int ch = HALF; ch < CHANNELS; ch++)
        begin
            if (pk_reg[ch] > max_hi_next)
            begin
                max_hi_next = pk_reg[ch];
            end
        end
    end

    // first channel at the maximum, tie flag
    always_comb
    begin
        mx = (max_lo_reg >= max_hi_reg) ? max_lo_reg : max_hi_reg;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            eq[ch] = (pk_reg[ch] == mx);
        end
        best_next = '0;
        for (int ch = CHANNELS - 1; ch >= 0; ch--)
        begin
            if (eq[ch])
            begin
                best_next = hpd_pkg::SEL_W'(ch);
            end
        end
    end

    assign num_next = (mx3_reg > 0)
                    ? NUM_W'(mx3_reg[SUM_W-1:0]) * SCALE + NUM_W'(HALF_D)
                    : '0;

    assign prod = (PW'(pp_hi_reg) << ML_W) + PW'(pp_lo_reg);
    assign quot = prod >> K;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= close;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (v5_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (close)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                pk_reg[ch] <= peaks[ch];
            end
        end
        max_lo_reg <= max_lo_next;
        max_hi_reg <= max_hi_next;
        mx3_reg    <= mx;
        best3_reg  <= best_next;
        tied3_reg  <= |(eq & (eq - CHANNELS'(1)));
        num4_reg   <= num_next;
        best4_reg  <= best3_reg;
        tied4_reg  <= tied3_reg;
        pp_lo_reg  <= (NUM_W+ML_W)'(num4_reg) * (NUM_W+ML_W)'(RECIP_LO);
        pp_hi_reg  <= (NUM_W+MH_W)'(num4_reg) * (NUM_W+MH_W)'(RECIP_HI);
        best5_reg  <= best4_reg;
        tied5_reg  <= tied4_reg;
        if (v5_reg)
        begin
            ring_reg     <= tied5_reg ? '0 : hpd_pkg::RING_MAP[best5_reg];
            peak_out_reg <= (quot > SAT_MAX) ? {hpd_pkg::PEAK_W{1'b1}}
                                             : quot[hpd_pkg::PEAK_W-1:0];
            best_out_reg <= best5_reg;
            tied_out_reg <= tied5_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ring_number     = ring_reg;
    assign peak_hundredths = peak_out_reg;
    assign best_channel    = best_out_reg;
    assign ambiguous       = tied_out_reg;
    assign busy            = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg | out_valid_reg;

endmodule

// ----- hdl/multichannel_hit_peak_detector.sv -----
// ----------------------------------------------------------------------------
// multichannel_hit_peak_detector
// baseline ring per channel, hit window detection and peak report per window
// ----------------------------------------------------------------------------
// result registers: peaks, half maxima, maximum, numerator, product, output
// throughput: one frame per cycle unless stalled; lanes update sums and peaks in
//   that cycle, the ring registers its next row ahead, writes a row per baseline
//   frame; s_axis_tready drops only while a window could close and a result is
//   in flight; reset clears phase, counters, sums and result valid flags, sets
//   registers to 20 / 50; ring contents stay undefined, the refill rewrites them
module multichannel_hit_peak_detector #(
    parameter int CHANNELS       = 10,
    parameter int BASELINE_DEPTH = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // sample_ch0 .. sample_ch9, 8 bits each
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // ring_number[3:0], peak_hundredths[19:4],
                                        // best_channel[23:20], ambiguous[24]
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam int SW    = hpd_pkg::SAMPLE_W;
    localparam int SUM_W = $clog2(hpd_pkg::SAMPLE_MAX * BASELINE_DEPTH + 1);
    localparam int AW    = $clog2(BASELINE_DEPTH);
    localparam int ROW_W = CHANNELS * SW;

    localparam logic [0:0] REG_HIT_THRESHOLD = 1'd0;
    localparam logic [0:0] REG_WINDOW_LENGTH = 1'd1;

    localparam logic [1:0] PH_BASE = 2'd0;
    localparam logic [1:0] PH_MON  = 2'd1;
    localparam logic [1:0] PH_WIN  = 2'd2;

    localparam logic [AW-1:0] LAST_ROW = AW'(BASELINE_DEPTH - 1);
    localparam logic [9:0]    WC_MAX   = 10'd1023;

    logic [7:0]             thr_reg;
    logic [9:0]             wlen_reg;
    logic [1:0]             phase_reg, phase_next;
    logic [AW-1:0]          fill_reg, fill_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [9:0]             wc_reg, wc_next, wc_inc;
    logic                   accept;
    logic                   hit_any;
    logic                   close_possible;
    logic                   merge_busy;
    hpd_pkg::lane_ctrl_t    ctrl;
    logic [SUM_W-1:0]       limit;
    logic [SW-1:0]          lane_sample [CHANNELS];
    logic [CHANNELS-1:0]    lane_hit;
    logic signed [SUM_W:0]  lane_peak [CHANNELS];
    logic [ROW_W-1:0]       frame_row;
    logic [ROW_W-1:0]       hist_mem [BASELINE_DEPTH];
    logic [ROW_W-1:0]       rd_row_reg;
    logic                   mem_we;
    logic [AW-1:0]          wr_addr;
    logic [hpd_pkg::SEL_W-1:0]  res_ring, res_best;
    logic [hpd_pkg::PEAK_W-1:0] res_peak;
    logic                   res_tied;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= 8'd20;
            wlen_reg <= 10'd50;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HIT_THRESHOLD: thr_reg  <= cfg_data[7:0];
                REG_WINDOW_LENGTH: wlen_reg <= cfg_data;
                default:           thr_reg  <= thr_reg;
            endcase
        end
    end

    assign limit = SUM_W'(thr_reg) * SUM_W'(BASELINE_DEPTH);

    // frame unpacking, channels beyond the input fields read as zero
    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++)
        begin : g_lane
            if (g < hpd_pkg::IN_FIELDS)
            begin : g_in
                assign lane_sample[g] = s_axis_tdata[g*SW +: SW];
            end
            else
            begin : g_zero
                assign lane_sample[g] = '0;
            end

            hpd_lane #(
                .DEPTH (BASELINE_DEPTH)
            ) u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .sample     (lane_sample[g]),
                .old_sample (rd_row_reg[g*SW +: SW]),
                .limit      (limit),
                .hit        (lane_hit[g]),
                .peak_upd   (lane_peak[g])
            );
        end
    endgenerate

    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            frame_row[ch*SW +: SW] = lane_sample[ch];
        end
    end

    assign hit_any        = |lane_hit;
    assign wc_inc         = (wc_reg < WC_MAX) ? wc_reg + 10'd1 : wc_reg;
    assign close_possible = (phase_reg == PH_WIN) && (wc_inc >= wlen_reg);
    assign s_axis_tready  = !(close_possible && merge_busy);
    assign accept         = s_axis_tvalid && s_axis_tready;

    // lane control and sequencing
    always_comb
    begin
        ctrl       = '0;
        phase_next = phase_reg;
        fill_next  = fill_reg;
        pos_next   = pos_reg;
        wc_next    = wc_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_BASE:
                begin
                    ctrl.base_add = 1'b1;
                    if (fill_reg == LAST_ROW)
                    begin
                        fill_next  = '0;
                        pos_next   = '0;
                        phase_next = PH_MON;
                    end
                    else
                    begin
                        fill_next = fill_reg + AW'(1);
                    end
                end
                PH_MON:
                begin
                    if (hit_any)
                    begin
                        ctrl.win_open = 1'b1;
                        wc_next       = 10'd1;
                        phase_next    = PH_WIN;
                    end
                    else
                    begin
                        ctrl.ring_upd = 1'b1;
                        pos_next      = (pos_reg == LAST_ROW) ? '0 : pos_reg + AW'(1);
                    end
                end
                PH_WIN:
                begin
                    ctrl.win_track = 1'b1;
                    wc_next        = wc_inc;
                    if (close_possible)
                    begin
                        ctrl.clear = 1'b1;
                        phase_next = PH_BASE;
                        fill_next  = '0;
                        pos_next   = '0;
                        wc_next    = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_BASE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BASE;
            fill_reg  <= '0;
            pos_reg   <= '0;
            wc_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
            wc_reg    <= wc_next;
        end
    end

    // baseline ring, next row read ahead into a register
    assign mem_we  = ctrl.base_add || ctrl.ring_upd;
    assign wr_addr = ctrl.base_add ? fill_reg : pos_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[wr_addr] <= frame_row;
        end
        rd_row_reg <= hist_mem[pos_next];
    end

    hpd_merge #(
        .CHANNELS (CHANNELS),
        .DEPTH    (BASELINE_DEPTH)
    ) u_merge (
        .clk             (clk),
        .rst_n           (rst_n),
        .close           (ctrl.clear),
        .peaks           (lane_peak),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .ring_number     (res_ring),
        .peak_hundredths (res_peak),
        .best_channel    (res_best),
        .ambiguous       (res_tied),
        .busy            (merge_busy)
    );

    assign m_axis_tdata = {7'd0, res_tied, res_best, res_peak, res_ring};

endmodule
